>>> hw/rtl/hcmm_pkg.sv
// Package for the handheld console memory map: region codes, controller
// state type, command/status structs and the address decode function.
// No dependencies.
`default_nettype none

package hcmm_pkg;

    localparam int WORK_RAM_DEPTH_DEF   = 8192;
    localparam int OBJECT_RAM_DEPTH_DEF = 160;
    localparam int HIGH_RAM_DEPTH_DEF   = 127;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 16;
    localparam int WDATA_W  = 16;
    localparam int REGION_W = 4;
    localparam int BYTE_W   = 8;

    localparam logic [REGION_W-1:0] REG_CART_FIXED  = 4'd0;
    localparam logic [REGION_W-1:0] REG_CART_BANKED = 4'd1;
    localparam logic [REGION_W-1:0] REG_VIDEO_RAM   = 4'd2;
    localparam logic [REGION_W-1:0] REG_CART_RAM    = 4'd3;
    localparam logic [REGION_W-1:0] REG_WORK_RAM    = 4'd4;
    localparam logic [REGION_W-1:0] REG_OAM         = 4'd5;
    localparam logic [REGION_W-1:0] REG_UNUSABLE    = 4'd6;
    localparam logic [REGION_W-1:0] REG_IO          = 4'd7;
    localparam logic [REGION_W-1:0] REG_HIGH_RAM    = 4'd8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic access;
        logic next_half;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic word;
        logic half;
    } dp_status_t;

    function automatic logic [REGION_W-1:0] decode_region(input logic [ADDR_W-1:0] a);
        logic [REGION_W-1:0] r;
        priority if (a < 16'h4000)
            r = REG_CART_FIXED;
        else if (a < 16'h8000)
            r = REG_CART_BANKED;
        else if (a < 16'hA000)
            r = REG_VIDEO_RAM;
        else if (a < 16'hC000)
            r = REG_CART_RAM;
        else if (a < 16'hFE00)
            r = REG_WORK_RAM;
        else if (a < 16'hFEA0)
            r = REG_OAM;
        else if (a < 16'hFF00)
            r = REG_UNUSABLE;
        else if (a == 16'hFFFF)
            r = REG_IO;
        else if (a < 16'hFF80)
            r = REG_IO;
        else
            r = REG_HIGH_RAM;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hcmm_ctrl.sv
// Controller state machine for the memory map: clearing pass, accept,
// byte access and result handshake.
// Depends on hcmm_pkg.
`default_nettype none

module hcmm_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  wire hcmm_pkg::dp_status_t status,
    output hcmm_pkg::dp_cmd_t         cmd
);

    hcmm_pkg::state_t state_reg;
    hcmm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hcmm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hcmm_pkg::ST_CLEAR:
            begin
                if (status.clear_last)
                    state_next = hcmm_pkg::ST_IDLE;
            end
            hcmm_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = hcmm_pkg::ST_ACCESS;
            end
            hcmm_pkg::ST_ACCESS:
            begin
                state_next = hcmm_pkg::ST_RESULT;
            end
            hcmm_pkg::ST_RESULT:
            begin
                if (m_tready)
                begin
                    if (status.word && !status.half)
                        state_next = hcmm_pkg::ST_ACCESS;
                    else
                        state_next = hcmm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcmm_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        unique case (state_reg)
            hcmm_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
            end
            hcmm_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            hcmm_pkg::ST_ACCESS:
            begin
                cmd.access = 1'b1;
            end
            hcmm_pkg::ST_RESULT:
            begin
                m_tvalid       = 1'b1;
                cmd.next_half  = m_tready && status.word && !status.half;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/hcmm_datapath.sv
// Datapath for the memory map: item and result registers, address decode,
// work RAM, OAM and high RAM stores with their clearing counter.
// Depends on hcmm_pkg.
`default_nettype none

module hcmm_datapath
#(
    parameter int WORK_RAM_DEPTH   = hcmm_pkg::WORK_RAM_DEPTH_DEF,
    parameter int OBJECT_RAM_DEPTH = hcmm_pkg::OBJECT_RAM_DEPTH_DEF,
    parameter int HIGH_RAM_DEPTH   = hcmm_pkg::HIGH_RAM_DEPTH_DEF
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire hcmm_pkg::dp_cmd_t               cmd,
    output hcmm_pkg::dp_status_t                 status,
    input  wire logic [hcmm_pkg::OP_W-1:0]       in_op,
    input  wire logic [hcmm_pkg::ADDR_W-1:0]     in_address,
    input  wire logic [hcmm_pkg::WDATA_W-1:0]    in_write_data,
    output logic [hcmm_pkg::REGION_W-1:0]        region,
    output logic [hcmm_pkg::ADDR_W-1:0]          byte_address,
    output logic                                 is_write,
    output logic [hcmm_pkg::BYTE_W-1:0]          byte_data,
    output logic                                 last
);

    localparam int WI_W = $clog2(WORK_RAM_DEPTH);
    localparam int OI_W = $clog2(OBJECT_RAM_DEPTH);
    localparam int HI_W = $clog2(HIGH_RAM_DEPTH);

    logic [hcmm_pkg::BYTE_W-1:0] wram [WORK_RAM_DEPTH];
    logic [hcmm_pkg::BYTE_W-1:0] oram [OBJECT_RAM_DEPTH];
    logic [hcmm_pkg::BYTE_W-1:0] hram [HIGH_RAM_DEPTH];

    logic [WI_W-1:0]                clr_cnt_reg;
    logic                           half_reg;
    logic [hcmm_pkg::OP_W-1:0]      op_reg;
    logic [hcmm_pkg::ADDR_W-1:0]    addr_reg;
    logic [hcmm_pkg::WDATA_W-1:0]   wdata_reg;

    logic [hcmm_pkg::REGION_W-1:0]  res_region_reg;
    logic [hcmm_pkg::ADDR_W-1:0]    res_addr_reg;
    logic                           res_wr_reg;
    logic [hcmm_pkg::BYTE_W-1:0]    res_wbyte_reg;
    logic                           res_last_reg;
    logic [hcmm_pkg::BYTE_W-1:0]    wram_rd_reg;
    logic [hcmm_pkg::BYTE_W-1:0]    oram_rd_reg;
    logic [hcmm_pkg::BYTE_W-1:0]    hram_rd_reg;

    logic [hcmm_pkg::ADDR_W-1:0]    cur_addr;
    logic [hcmm_pkg::REGION_W-1:0]  cur_region;
    logic [hcmm_pkg::BYTE_W-1:0]    cur_wbyte;
    logic                           cur_wr;
    logic                           oram_clr;
    logic                           hram_clr;

    assign cur_addr   = addr_reg + {{(hcmm_pkg::ADDR_W-1){1'b0}}, half_reg};
    assign cur_region = hcmm_pkg::decode_region(cur_addr);
    assign cur_wbyte  = half_reg ? wdata_reg[15:8] : wdata_reg[7:0];
    assign cur_wr     = op_reg[0];
    assign oram_clr   = cmd.clear_step && (clr_cnt_reg < WI_W'(OBJECT_RAM_DEPTH));
    assign hram_clr   = cmd.clear_step && (clr_cnt_reg < WI_W'(HIGH_RAM_DEPTH));

    assign status.clear_last = (clr_cnt_reg == WI_W'(WORK_RAM_DEPTH - 1));
    assign status.word       = op_reg[1];
    assign status.half       = half_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            half_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (cmd.load)
                half_reg <= 1'b0;
            else if (cmd.next_half)
                half_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= in_op;
            addr_reg  <= in_address;
            wdata_reg <= in_write_data;
        end
        if (cmd.access)
        begin
            res_region_reg <= cur_region;
            res_addr_reg   <= cur_addr;
            res_wr_reg     <= cur_wr;
            res_wbyte_reg  <= cur_wbyte;
            res_last_reg   <= !op_reg[1] || half_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            wram[clr_cnt_reg] <= '0;
        else if (cmd.access && cur_region == hcmm_pkg::REG_WORK_RAM)
        begin
            wram_rd_reg <= wram[cur_addr[WI_W-1:0]];
            if (cur_wr)
                wram[cur_addr[WI_W-1:0]] <= cur_wbyte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (oram_clr)
            oram[clr_cnt_reg[OI_W-1:0]] <= '0;
        else if (cmd.access && cur_region == hcmm_pkg::REG_OAM)
        begin
            oram_rd_reg <= oram[cur_addr[OI_W-1:0]];
            if (cur_wr)
                oram[cur_addr[OI_W-1:0]] <= cur_wbyte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hram_clr)
            hram[clr_cnt_reg[HI_W-1:0]] <= '0;
        else if (cmd.access && cur_region == hcmm_pkg::REG_HIGH_RAM)
        begin
            hram_rd_reg <= hram[cur_addr[HI_W-1:0]];
            if (cur_wr)
                hram[cur_addr[HI_W-1:0]] <= cur_wbyte;
        end
    end

    assign region       = res_region_reg;
    assign byte_address = res_addr_reg;
    assign is_write     = res_wr_reg;
    assign last         = res_last_reg;

    always_comb
    begin
        if (res_wr_reg)
            byte_data = res_wbyte_reg;
        else
        begin
            unique case (res_region_reg)
                hcmm_pkg::REG_WORK_RAM: byte_data = wram_rd_reg;
                hcmm_pkg::REG_OAM:      byte_data = oram_rd_reg;
                hcmm_pkg::REG_HIGH_RAM: byte_data = hram_rd_reg;
                default:                byte_data = '0;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/handheld_console_memory_map.sv
// Handheld console memory map: a 16-bit CPU bus decoder with on-chip work
// RAM (C000-DFFF, mirrored at E000-FDFF), OAM (FE00-FE9F) and high RAM
// (FF80-FFFE). A word access is split into a low byte at the address and a
// high byte at the address plus 1, the high byte beat marked with tlast.
// After reset the block runs a clearing pass over all WORK_RAM_DEPTH work
// RAM addresses (8192 by default) that also clears OAM and high RAM, and
// holds s_tready low until it is done. One item is handled at a time: a new
// item is taken only after the last result beat of the one before has been
// taken, as each byte goes through a single-port store access in ACCESS and
// a registered result beat in RESULT.
// Depends on hcmm_pkg, hcmm_ctrl and hcmm_datapath.
`default_nettype none

module handheld_console_memory_map
#(
    parameter int WORK_RAM_DEPTH   = hcmm_pkg::WORK_RAM_DEPTH_DEF,
    parameter int OBJECT_RAM_DEPTH = hcmm_pkg::OBJECT_RAM_DEPTH_DEF,
    parameter int HIGH_RAM_DEPTH   = hcmm_pkg::HIGH_RAM_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // address[15:0], write_data[31:16]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // byte_address[15:0], byte_data[23:16]
    output logic [4:0]       m_tuser,   // region[3:0], is_write[4]
    output logic             m_tlast
);

    hcmm_pkg::dp_cmd_t    cmd;
    hcmm_pkg::dp_status_t status;

    logic [hcmm_pkg::REGION_W-1:0] region;
    logic [hcmm_pkg::ADDR_W-1:0]   byte_address;
    logic                          is_write;
    logic [hcmm_pkg::BYTE_W-1:0]   byte_data;

    hcmm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hcmm_datapath
    #(
        .WORK_RAM_DEPTH   (WORK_RAM_DEPTH),
        .OBJECT_RAM_DEPTH (OBJECT_RAM_DEPTH),
        .HIGH_RAM_DEPTH   (HIGH_RAM_DEPTH)
    )
    u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .in_op         (s_tuser),
        .in_address    (s_tdata[15:0]),
        .in_write_data (s_tdata[31:16]),
        .region        (region),
        .byte_address  (byte_address),
        .is_write      (is_write),
        .byte_data     (byte_data),
        .last          (m_tlast)
    );

    assign m_tdata = {byte_data, byte_address};
    assign m_tuser = {is_write, region};

endmodule

`default_nettype wire

>>> tb/hcmm_beat_checker.sv
// Scoreboard for the handheld console memory map: watches both stream channels,
// predicts the result beats of every accepted access and compares them in order.
// Depends on hcmm_pkg for widths, store depths and region codes.
`default_nettype none

module hcmm_beat_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // address[15:0], write_data[31:16]
    input  wire logic [1:0]  s_tuser,   // op[1:0]
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,   // byte_address[15:0], byte_data[23:16]
    input  wire logic [4:0]  m_tuser,   // region[3:0], is_write[4]
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               pending,
    output int               beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_WRITE_BIT = 0;
    localparam int OP_WORD_BIT  = 1;

    typedef struct packed {
        logic [hcmm_pkg::REGION_W-1:0] region;
        logic [hcmm_pkg::ADDR_W-1:0]   addr;
        logic                          is_write;
        logic [hcmm_pkg::BYTE_W-1:0]   data;
        logic                          last;
    } byte_beat_t;

    logic [hcmm_pkg::BYTE_W-1:0] work_mem [hcmm_pkg::WORK_RAM_DEPTH_DEF];
    logic [hcmm_pkg::BYTE_W-1:0] oam_mem  [hcmm_pkg::OBJECT_RAM_DEPTH_DEF];
    logic [hcmm_pkg::BYTE_W-1:0] hram_mem [hcmm_pkg::HIGH_RAM_DEPTH_DEF];

    byte_beat_t expected_beats [$];

    function automatic logic [hcmm_pkg::REGION_W-1:0] region_of(
        input logic [hcmm_pkg::ADDR_W-1:0] a);
        case (a[15:13])
            3'b000, 3'b001: return hcmm_pkg::REG_CART_FIXED;
            3'b010, 3'b011: return hcmm_pkg::REG_CART_BANKED;
            3'b100:         return hcmm_pkg::REG_VIDEO_RAM;
            3'b101:         return hcmm_pkg::REG_CART_RAM;
            3'b110:         return hcmm_pkg::REG_WORK_RAM;
            default:
            begin
                // E000-FDFF mirrors work RAM
                if (a[15:9] != 7'h7F)
                    return hcmm_pkg::REG_WORK_RAM;
                if (!a[8])
                    return (a[7:0] < 8'hA0) ? hcmm_pkg::REG_OAM : hcmm_pkg::REG_UNUSABLE;
                if (!a[7] || a[6:0] == 7'h7F)
                    return hcmm_pkg::REG_IO;
                return hcmm_pkg::REG_HIGH_RAM;
            end
        endcase
    endfunction

    // Applies one byte access to the shadow stores and returns its result beat.
    function automatic byte_beat_t access_byte(input logic [hcmm_pkg::ADDR_W-1:0] a,
                                               input logic wr,
                                               input logic [hcmm_pkg::BYTE_W-1:0] wd,
                                               input logic last);
        byte_beat_t b;
        b.region   = region_of(a);
        b.addr     = a;
        b.is_write = wr;
        b.data     = wr ? wd : '0;
        b.last     = last;
        case (b.region)
            hcmm_pkg::REG_WORK_RAM:
            begin
                if (wr)
                    work_mem[a[12:0]] = wd;
                else
                    b.data = work_mem[a[12:0]];
            end
            hcmm_pkg::REG_OAM:
            begin
                if (wr)
                    oam_mem[a[7:0]] = wd;
                else
                    b.data = oam_mem[a[7:0]];
            end
            hcmm_pkg::REG_HIGH_RAM:
            begin
                if (wr)
                    hram_mem[a[6:0]] = wd;
                else
                    b.data = hram_mem[a[6:0]];
            end
            default: ;
        endcase
        return b;
    endfunction

    task automatic flag_beat(input string why, input byte_beat_t want, input byte_beat_t got);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("[%0t] %s: exp region %0d addr %h wr %0b data %h last %0b",
                     $realtime, why, want.region, want.addr, want.is_write, want.data,
                     want.last);
            $display("    got region %0d addr %h wr %0b data %h last %0b",
                     got.region, got.addr, got.is_write, got.data, got.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        byte_beat_t got;
        byte_beat_t want;
        logic [1:0] op;
        logic [hcmm_pkg::ADDR_W-1:0] a;
        logic [hcmm_pkg::WDATA_W-1:0] wd;
        if (!rst_n)
        begin
            foreach (work_mem[i]) work_mem[i] = '0;
            foreach (oam_mem[i]) oam_mem[i] = '0;
            foreach (hram_mem[i]) hram_mem[i] = '0;
            expected_beats.delete();
            fail_count    = 0;
            pending       = 0;
            beats_checked = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = '{m_tuser[3:0], m_tdata[15:0], m_tuser[4], m_tdata[23:16], m_tlast};
                beats_checked++;
                if (expected_beats.size() == 0)
                    flag_beat("unexpected beat", '0, got);
                else
                begin
                    want = expected_beats.pop_front();
                    if (got !== want)
                        flag_beat("beat mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready)
            begin
                op = s_tuser;
                a  = s_tdata[15:0];
                wd = s_tdata[31:16];
                if (op[OP_WORD_BIT])
                begin
                    expected_beats.push_back(access_byte(a, op[OP_WRITE_BIT], wd[7:0], 1'b0));
                    expected_beats.push_back(access_byte(a + 16'd1, op[OP_WRITE_BIT],
                                                         wd[15:8], 1'b1));
                end
                else
                    expected_beats.push_back(access_byte(a, op[OP_WRITE_BIT], wd[7:0], 1'b1));
            end
            pending = expected_beats.size();
        end
    end

endmodule

`default_nettype wire

>>> tb/handheld_console_memory_map_tb.sv
// Testbench top for the handheld console memory map: clock, reset, directed and
// random bus accesses with idle/stall phases; verdict from hcmm_beat_checker.
// Depends on hcmm_pkg, handheld_console_memory_map and hcmm_beat_checker.
`default_nettype none

module handheld_console_memory_map_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        OP_BYTE_READ,
        OP_BYTE_WRITE,
        OP_WORD_READ,
        OP_WORD_WRITE
    } bus_op_t;

    localparam int ITEMS_PER_PHASE = 207;
    localparam int HOLD_OFF_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // address[15:0], write_data[31:16]
    logic [1:0]  s_tuser;   // op[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // byte_address[15:0], byte_data[23:16]
    logic [4:0]  m_tuser;   // region[3:0], is_write[4]
    logic        m_tlast;

    int fail_count;
    int pending;
    int beats_checked;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_request;
    int accesses_sent;

    logic [15:0] recent_addr [16];

    handheld_console_memory_map DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    hcmm_beat_checker beat_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random stalls, plus long hold-offs on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_access(input bus_op_t op, input logic [15:0] a, input logic [15:0] wd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {wd, a};
        s_tuser  <= op;
        do
            @(posedge clk);
        while (s_tready !== 1'b1);
        accesses_sent++;
        if (op == OP_BYTE_WRITE || op == OP_WORD_WRITE)
            recent_addr[$urandom_range(15)] = a;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_address();
        case ($urandom_range(9))
            0, 1, 2: return 16'($urandom);
            3, 4, 5: return 16'($urandom_range(16'hFDFF, 16'hC000));
            6:       return 16'($urandom_range(16'hFE9F, 16'hFE00));
            7:       return 16'($urandom_range(16'hFFFF, 16'hFE9F));
            8:       return 16'($urandom_range(16'hFFFF, 16'hFF7F));
            default: return recent_addr[$urandom_range(15)] + 16'($urandom_range(2)) - 16'd1;
        endcase
    endfunction

    initial
    begin
        accesses_sent  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        foreach (recent_addr[i]) recent_addr[i] = 16'hC000 + 16'(i);
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_BYTE_READ;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // region edges, mirror, word wrap and boundary-crossing words
        send_access(OP_BYTE_READ,  16'h0000, 16'h0000);
        send_access(OP_WORD_WRITE, 16'h3FFF, 16'hA55A);
        send_access(OP_BYTE_READ,  16'h7FFF, 16'hFFFF);
        send_access(OP_BYTE_WRITE, 16'h8000, 16'h00FF);
        send_access(OP_WORD_READ,  16'h9FFF, 16'h0000);
        send_access(OP_BYTE_WRITE, 16'hBFFF, 16'h1234);
        send_access(OP_WORD_WRITE, 16'hC000, 16'hBEEF);
        send_access(OP_WORD_READ,  16'hE000, 16'h0000);
        send_access(OP_BYTE_WRITE, 16'hFDFF, 16'h0077);
        send_access(OP_BYTE_READ,  16'hDDFF, 16'h0000);
        send_access(OP_WORD_READ,  16'hDFFF, 16'h0000);
        send_access(OP_WORD_WRITE, 16'hFDFF, 16'hC35A);
        send_access(OP_WORD_WRITE, 16'hFE9E, 16'h8001);
        send_access(OP_WORD_READ,  16'hFE9F, 16'h0000);
        send_access(OP_BYTE_WRITE, 16'hFEFF, 16'h00AA);
        send_access(OP_BYTE_READ,  16'hFEFF, 16'h0000);
        send_access(OP_WORD_WRITE, 16'hFF7F, 16'h6699);
        send_access(OP_WORD_READ,  16'hFF7F, 16'h0000);
        send_access(OP_WORD_WRITE, 16'hFFFE, 16'hF00D);
        send_access(OP_WORD_READ,  16'hFFFE, 16'h0000);
        send_access(OP_WORD_WRITE, 16'hFFFF, 16'hFFFF);
        send_access(OP_WORD_READ,  16'hFFFF, 16'h0000);
        send_access(OP_BYTE_READ,  16'hFF00, 16'h0000);
        drain_results();

        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1) ? 67 : (phase == 3) ? 27 : 0;
            recv_stall_pct = (phase == 2) ? 67 : (phase == 3) ? 27 : 0;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 0 && n == 50)
                    hold_request = HOLD_OFF_CYCLES;
                send_access(bus_op_t'($urandom_range(3)), pick_address(), 16'($urandom));
            end
            drain_results();
        end

        recv_stall_pct = 0;
        wait (pending == 0);
        repeat (16) @(posedge clk);
        $display("Ran %0d bus accesses (%0d result beats) over every region and boundary,",
                 accesses_sent, beats_checked);
        $display("under idle, stall and long back-pressure phases.");
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("Timeout with %0d result beats outstanding", pending);
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/hcmm_pkg.sv
hw/rtl/hcmm_ctrl.sv
hw/rtl/hcmm_datapath.sv
hw/rtl/handheld_console_memory_map.sv
tb/hcmm_beat_checker.sv
tb/handheld_console_memory_map_tb.sv
